### src/uart_baud_divisor_calc_assert.svh
// assertion macros for the baud divisor calculator checks
`ifndef UART_BAUD_DIVISOR_CALC_ASSERT_SVH
`define UART_BAUD_DIVISOR_CALC_ASSERT_SVH

// antecedent implies consequent on the same edge
`define UDC_ASSERT_IMPLY(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("udc check failed");

// condition holds at every edge out of reset
`define UDC_ASSERT_ALWAYS(lbl, clk, rst, cond) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cond)) \
      else $error("udc check failed");

`endif

### src/udc_pkg.sv
// shared types and constants of the baud divisor calculator
package udc_pkg;

   localparam int BAUD_W       = 24;
   localparam int PCLK_W       = 28;
   localparam int DIVIDEND_W   = 33;
   localparam int DIV_BITS     = DIVIDEND_W;
   localparam int WORD_W       = 16;
   localparam int STATUS_W     = 2;
   localparam int CSR_INDEX_W  = 1;
   localparam int CSR_DATA_W   = PCLK_W;

   localparam int LOW_W        = 19;
   localparam int RECIP_MANT_W = 21;
   localparam int PROD_W       = LOW_W + RECIP_MANT_W;
   localparam int RECIP_MANT_SH = 27;
   localparam int MANT_W       = PROD_W - RECIP_MANT_SH;
   localparam int REM_W        = 7;
   localparam int FRAC_V_W     = 11;
   localparam int RECIP_FRAC_W = 11;
   localparam int FRAC_P_W     = FRAC_V_W + RECIP_FRAC_W;
   localparam int RECIP_FRAC_SH = 17;
   localparam int FRAC_W       = FRAC_P_W - RECIP_FRAC_SH;

   localparam logic [PCLK_W-1:0]       PCLK_RESET   = PCLK_W'(42000000);
   localparam logic [LOW_W-1:0]        DIV_SCALE    = LOW_W'(100);
   localparam logic [FRAC_V_W-1:0]     ROUND_HALF   = FRAC_V_W'(50);
   localparam logic [MANT_W-1:0]       MANT_MAX     = MANT_W'(4095);
   localparam logic [DIVIDEND_W-1:0]   SAT_LIMIT    = DIVIDEND_W'(409600);
   localparam logic [RECIP_MANT_W-1:0] RECIP_MANT   = RECIP_MANT_W'(1342178);
   localparam logic [RECIP_FRAC_W-1:0] RECIP_FRAC   = RECIP_FRAC_W'(1311);
   localparam logic [FRAC_W-1:0]       FRAC_LIM_8   = FRAC_W'(8);
   localparam logic [FRAC_W-1:0]       FRAC_LIM_16  = FRAC_W'(16);
   localparam logic [WORD_W-1:0]       SAT_WORD     = 16'hFFFF;

   localparam logic [STATUS_W-1:0] ST_OK        = 2'd0;
   localparam logic [STATUS_W-1:0] ST_BAUD_ZERO = 2'd1;
   localparam logic [STATUS_W-1:0] ST_SATURATED = 2'd2;

   localparam logic [CSR_INDEX_W-1:0] CSR_PCLK_HZ    = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_OVER8_MODE = 1'b1;

   // strobe is sampled this many edges after the request edge
   localparam int RSP_LATENCY = DIV_BITS + 4;

   typedef struct packed {
      logic                  valid;
      logic                  zero;
      logic                  over8;
      logic [BAUD_W-1:0]     rem;
      logic [DIVIDEND_W-1:0] dq;
      logic [BAUD_W-1:0]     dvsr;
   } div_cell_type;

endpackage

### src/uart_baud_divisor_calc.sv
// top level of the fractional baud divisor calculator
//
// A request is taken at a clock edge with start high and busy low; its
// baud rate is on req_baud_rate. busy is high while reset is held and until
// the first clock edge without reset; after that one request per cycle is accepted
// back to back.
// Each request gives one response: rsp_valid strobes for one cycle with
// rsp_divisor_word and rsp_status.
// The pipeline is one input register, 33 divider cells that each resolve
// one quotient bit, and three stages that split the quotient into mantissa
// and rounded fraction and register the result.
// Throughput is one request per clock cycle.
// The pclk_hz and over8_mode registers are written on the csr_ port, index
// 0 and 1; the user must change them only while no request is in flight,
// which the block itself does not enforce. Synchronous reset empties the
// pipeline and restores pclk_hz to 42000000 and the by-sixteen mode. The
// receiver cannot stall: a response is on the ports for its one cycle only.
module uart_baud_divisor_calc (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  logic [udc_pkg::BAUD_W-1:0]        req_baud_rate,
   output logic                              rsp_valid,
   output logic [udc_pkg::WORD_W-1:0]        rsp_divisor_word,
   output logic [udc_pkg::STATUS_W-1:0]      rsp_status,
   input  logic                              csr_wr_en,
   input  logic [udc_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  logic [udc_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import udc_pkg::*;

   logic [PCLK_W-1:0]     pclk_hz_ff;
   logic                  over8_mode_ff;
   logic                  busy_ff;
   logic [DIVIDEND_W-1:0] scaled;
   logic [DIVIDEND_W-1:0] dividend;
   logic                  accept;
   logic                  in_valid_ff;
   div_cell_type          in_data_in;
   div_cell_type          in_data_ff;
   div_cell_type          chain [DIV_BITS+1];

   always_ff @(posedge clock) begin
      if (reset) begin
         pclk_hz_ff    <= PCLK_RESET;
         over8_mode_ff <= 1'b0;
         busy_ff       <= 1'b1;
      end else begin
         busy_ff <= 1'b0;
         if (csr_wr_en) begin
            case (csr_index)
               CSR_PCLK_HZ:    pclk_hz_ff    <= csr_wdata[PCLK_W-1:0];
               CSR_OVER8_MODE: over8_mode_ff <= csr_wdata[0];
               default:        ;
            endcase
         end
      end
   end

   assign busy   = busy_ff;
   assign accept = start && !busy_ff;

   // pclk * 25, then divided by 4 or by 2
   always_comb begin
      scaled = (DIVIDEND_W'(pclk_hz_ff) << 4) + (DIVIDEND_W'(pclk_hz_ff) << 3)
             + DIVIDEND_W'(pclk_hz_ff);
      dividend = over8_mode_ff ? (scaled >> 1) : (scaled >> 2);
      in_data_in.valid = accept;
      in_data_in.zero  = (req_baud_rate == '0);
      in_data_in.over8 = over8_mode_ff;
      in_data_in.rem   = '0;
      in_data_in.dq    = dividend;
      in_data_in.dvsr  = req_baud_rate;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= accept;
      end
   end

   always_ff @(posedge clock) begin
      in_data_ff <= in_data_in;
   end

   always_comb begin
      chain[0]       = in_data_ff;
      chain[0].valid = in_valid_ff;
   end

   for (genvar gi = 0; gi < DIV_BITS; gi++) begin : g_cell
      udc_div_cell u_cell (
         .clock    (clock),
         .reset    (reset),
         .cell_in  (chain[gi]),
         .cell_out (chain[gi+1])
      );
   end

   udc_post u_post (
      .clock            (clock),
      .reset            (reset),
      .quot_in          (chain[DIV_BITS]),
      .rsp_valid        (rsp_valid),
      .rsp_divisor_word (rsp_divisor_word),
      .rsp_status       (rsp_status)
   );

endmodule

### src/udc_div_cell.sv
// one restoring divider cell: one quotient bit per stage
module udc_div_cell (
   input  logic                 clock,
   input  logic                 reset,
   input  udc_pkg::div_cell_type cell_in,
   output udc_pkg::div_cell_type cell_out
);
   import udc_pkg::*;

   logic [BAUD_W:0] trial;
   logic [BAUD_W:0] diff;
   logic            fits;
   logic            valid_ff;
   div_cell_type    data_in;
   div_cell_type    data_ff;

   always_comb begin
      trial   = {cell_in.rem, cell_in.dq[DIVIDEND_W-1]};
      diff    = trial - {1'b0, cell_in.dvsr};
      fits    = (trial >= {1'b0, cell_in.dvsr});
      data_in = cell_in;
      data_in.rem = fits ? diff[BAUD_W-1:0] : trial[BAUD_W-1:0];
      data_in.dq  = {cell_in.dq[DIVIDEND_W-2:0], fits};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= cell_in.valid;
      end
   end

   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   always_comb begin
      cell_out       = data_ff;
      cell_out.valid = valid_ff;
   end

endmodule

### src/udc_post.sv
// quotient split into mantissa and rounded fraction, saturation and output register
module udc_post (
   input  logic                           clock,
   input  logic                           reset,
   input  udc_pkg::div_cell_type          quot_in,
   output logic                           rsp_valid,
   output logic [udc_pkg::WORD_W-1:0]     rsp_divisor_word,
   output logic [udc_pkg::STATUS_W-1:0]   rsp_status
);
   import udc_pkg::*;

   // stage 1: range check and reciprocal product
   logic                  p1_valid_ff;
   logic                  p1_zero_ff;
   logic                  p1_over8_ff;
   logic                  p1_big_ff;
   logic [LOW_W-1:0]      p1_x_ff;
   logic [PROD_W-1:0]     p1_prod_ff;
   logic [PROD_W-1:0]     p1_prod_in;
   logic                  p1_big_in;

   // stage 2: mantissa and remainder
   logic                  p2_valid_ff;
   logic                  p2_zero_ff;
   logic                  p2_over8_ff;
   logic                  p2_big_ff;
   logic [MANT_W-1:0]     p2_mant_ff;
   logic [REM_W-1:0]      p2_rem_ff;
   logic [MANT_W-1:0]     p2_mant_in;
   logic [LOW_W-1:0]      p2_rem_full;

   // stage 3: fraction rounding, carry and result
   logic [FRAC_V_W-1:0]   frac_v;
   logic [FRAC_P_W-1:0]   frac_p;
   logic [FRAC_W-1:0]     frac_raw;
   logic                  frac_carry;
   logic [3:0]            frac;
   logic [MANT_W-1:0]     mant_final;
   logic                  sat;
   logic                  out_valid_ff;
   logic [WORD_W-1:0]     out_word_ff;
   logic [STATUS_W-1:0]   out_status_ff;
   logic [WORD_W-1:0]     out_word_in;
   logic [STATUS_W-1:0]   out_status_in;

   always_comb begin
      p1_big_in  = (quot_in.dq >= SAT_LIMIT);
      p1_prod_in = PROD_W'(quot_in.dq[LOW_W-1:0]) * PROD_W'(RECIP_MANT);
   end

   always_comb begin
      p2_mant_in  = p1_prod_ff[PROD_W-1:RECIP_MANT_SH];
      p2_rem_full = p1_x_ff - (LOW_W'(p2_mant_in) * DIV_SCALE);
   end

   always_comb begin
      frac_v = p2_over8_ff ? FRAC_V_W'({p2_rem_ff, 3'b000})
                           : FRAC_V_W'({p2_rem_ff, 4'b0000});
      frac_v = frac_v + ROUND_HALF;
      frac_p = FRAC_P_W'(frac_v) * FRAC_P_W'(RECIP_FRAC);
      frac_raw   = frac_p[FRAC_P_W-1:RECIP_FRAC_SH];
      frac_carry = p2_over8_ff ? (frac_raw >= FRAC_LIM_8) : (frac_raw >= FRAC_LIM_16);
      frac       = frac_carry ? 4'd0 : frac_raw[3:0];
      mant_final = p2_mant_ff + MANT_W'(frac_carry);
      sat        = p2_big_ff || (mant_final > MANT_MAX);
      if (p2_zero_ff) begin
         out_word_in   = '0;
         out_status_in = ST_BAUD_ZERO;
      end else if (sat) begin
         out_word_in   = SAT_WORD;
         out_status_in = ST_SATURATED;
      end else begin
         out_word_in   = {mant_final[WORD_W-5:0], frac};
         out_status_in = ST_OK;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         p1_valid_ff  <= 1'b0;
         p2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         p1_valid_ff  <= quot_in.valid;
         p2_valid_ff  <= p1_valid_ff;
         out_valid_ff <= p2_valid_ff;
      end
   end

   always_ff @(posedge clock) begin
      p1_zero_ff    <= quot_in.zero;
      p1_over8_ff   <= quot_in.over8;
      p1_big_ff     <= p1_big_in;
      p1_x_ff       <= quot_in.dq[LOW_W-1:0];
      p1_prod_ff    <= p1_prod_in;
      p2_zero_ff    <= p1_zero_ff;
      p2_over8_ff   <= p1_over8_ff;
      p2_big_ff     <= p1_big_ff;
      p2_mant_ff    <= p2_mant_in;
      p2_rem_ff     <= p2_rem_full[REM_W-1:0];
      out_word_ff   <= out_word_in;
      out_status_ff <= out_status_in;
   end

   assign rsp_valid        = out_valid_ff;
   assign rsp_divisor_word = out_word_ff;
   assign rsp_status       = out_status_ff;

endmodule

### src/udc_checker.sv
// port-level checks of the baud divisor calculator and their binding
`include "uart_baud_divisor_calc_assert.svh"

module udc_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            start,
   input logic                            busy,
   input logic [udc_pkg::BAUD_W-1:0]      req_baud_rate,
   input logic                            rsp_valid,
   input logic [udc_pkg::WORD_W-1:0]      rsp_divisor_word,
   input logic [udc_pkg::STATUS_W-1:0]    rsp_status
);
   import udc_pkg::*;

   // every response traces back to a request at the fixed latency
   `UDC_ASSERT_IMPLY(a_rsp_has_req, clock, reset, rsp_valid, $past(start && !busy, RSP_LATENCY))

   // zero baud status only for a zero request, with a zero word
   `UDC_ASSERT_IMPLY(a_zero_baud, clock, reset, rsp_valid && (rsp_status == ST_BAUD_ZERO), (rsp_divisor_word == '0) && ($past(req_baud_rate, RSP_LATENCY) == '0))

   // saturation always shows the all-ones word
   `UDC_ASSERT_IMPLY(a_sat_word, clock, reset, rsp_valid && (rsp_status == ST_SATURATED), rsp_divisor_word == SAT_WORD)

   // a nonzero request never reports zero baud
   `UDC_ASSERT_IMPLY(a_nonzero_req, clock, reset, rsp_valid && ($past(req_baud_rate, RSP_LATENCY) != '0), rsp_status != ST_BAUD_ZERO)

   `UDC_ASSERT_ALWAYS(a_status_code, clock, reset, !rsp_valid || (rsp_status == ST_OK) || (rsp_status == ST_BAUD_ZERO) || (rsp_status == ST_SATURATED))

endmodule

bind uart_baud_divisor_calc udc_checker u_udc_checker (.*);
